/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int PRIO_W   = 8;
    localparam int OCC_W    = 5;
    localparam int STAT_W   = 2;

    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [PRIO_W-1:0]       prio;
    } t_entry;

    // shift controls broadcast to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_cell_ctrl;

endpackage

/* sv/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds an entry, shifts right on insert
// behind the new entry, shifts left on head removal.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occupied,
    input  logic                i_ins_left,
    input  spq_pkg::t_entry     i_left,
    input  spq_pkg::t_entry     i_right,
    output logic                o_ins,
    output spq_pkg::t_entry     o_entry
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // new entry belongs at or before this slot
    assign o_ins   = !i_occupied || (r_entry.prio > i_ctrl.item.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq) begin
            if (i_ins_left) begin
                n_entry = i_left;
            end else if (o_ins) begin
                n_entry = i_ctrl.item;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* sv/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a row of shift cells sorted by priority.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_valid / o_stall carry i_op, i_item_value and
//   i_item_priority. Op enqueue inserts ahead of the first held entry with a
//   strictly greater priority; op dequeue removes the head (lowest priority,
//   oldest among equals).
//   Result channel: o_valid / i_stall carry o_status, o_out_value,
//   o_out_priority and o_occupancy, one result per request.
//   Timing: the result is presented in the cycle after the request is taken.
//   Throughput: one request per cycle unless o_stall; each cell compares
//   with the new priority and shifts in the same cycle: the row updates in one step.
//   Stall: a held result stays in its register while i_stall is high; o_stall rises
//   only while a held result is blocked, so a request is still taken in
//   the cycle the pending result leaves.
//   Reset: synchronous, active low; the queue empties and no result is
//   pending. Cell contents are not cleared, only the entry count.
//   A full enqueue or empty dequeue leaves the queue unchanged.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_op,
    input  logic signed [spq_pkg::VAL_W-1:0]  i_item_value,
    input  logic [spq_pkg::PRIO_W-1:0]        i_item_priority,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [spq_pkg::STAT_W-1:0]        o_status,
    output logic signed [spq_pkg::VAL_W-1:0]  o_out_value,
    output logic [spq_pkg::PRIO_W-1:0]        o_out_priority,
    output logic [spq_pkg::OCC_W-1:0]         o_occupancy
);
    import spq_pkg::*;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic signed [VAL_W-1:0]  r_value;
    logic signed [VAL_W-1:0]  n_value;
    logic [PRIO_W-1:0]        r_prio;
    logic [PRIO_W-1:0]        n_prio;

    logic       w_accept;
    logic       w_full;
    logic       w_empty;
    t_cell_ctrl w_ctrl;
    t_entry     w_entry [CAPACITY];
    logic       w_ins   [CAPACITY];

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    assign w_ctrl.enq        = w_accept && (t_op'(i_op) == OP_ENQ) && !w_full;
    assign w_ctrl.deq        = w_accept && (t_op'(i_op) == OP_DEQ) && !w_empty;
    assign w_ctrl.item.value = i_item_value;
    assign w_ctrl.item.prio  = i_item_priority;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   w_occ;
        logic   w_ins_left;
        t_entry w_left;
        t_entry w_right;

        assign w_occ = (r_count > CNT_W'(g));

        if (g == 0) begin : g_first
            assign w_ins_left = 1'b0;
            assign w_left     = w_ctrl.item;
        end else begin : g_mid
            assign w_ins_left = w_ins[g-1];
            assign w_left     = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_occupied (w_occ),
            .i_ins_left (w_ins_left),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_ins      (w_ins[g]),
            .o_entry    (w_entry[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_ENQ;
        n_value  = '0;
        n_prio   = '0;
        if (t_op'(i_op) == OP_ENQ) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status = ST_DEQ;
                n_value  = w_entry[0].value;
                n_prio   = w_entry[0].prio;
                n_count  = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_prio   <= n_prio;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_out_value    = r_value;
    assign o_out_priority = r_prio;
    assign o_occupancy    = OCC_W'(r_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("entry count changed without a request");

    a_enq_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.enq |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("enqueue did not grow the queue");

    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (t_op'(i_op) == OP_DEQ) && w_empty |=> o_status == ST_EMPTY)
        else $error("dequeue on empty queue not reported");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CNT_W'(2) |-> w_entry[0].prio <= w_entry[1].prio)
        else $error("head entries out of order");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_priority_queue. Requests go in with random
// gaps and results drain under random stall. A scoreboard keeps its own
// sorted copy of the queue and checks every result against it in order.
// ----------------------------------------------------------------------------
module tb_top;
    import spq_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_REQUESTS = 1850;
    localparam int QUIET_TAIL      = 200;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] value;
        logic [PRIO_W-1:0]       prio;
        logic [OCC_W-1:0]        occ;
    } t_result;

    class queue_scoreboard;
        t_entry  held_entries[$];
        t_result awaited_results[$];
        int      errors;
        int      reported;
        int      enq_count;
        int      deq_count;
        int      full_hits;
        int      empty_hits;
        int      checked;

        function new();
            errors     = 0;
            reported   = 0;
            enq_count  = 0;
            deq_count  = 0;
            full_hits  = 0;
            empty_hits = 0;
            checked    = 0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (reported < MAX_REPORTS) begin
                reported++;
                $display("MISMATCH: %s", msg);
            end
        endfunction

        // accepted request: update the sorted copy and queue the result it owes
        function void note_request(t_op op, logic signed [VAL_W-1:0] value,
                                   logic [PRIO_W-1:0] prio);
            t_result res;
            t_entry  ent;
            int      pos;
            res = '0;
            if (op == OP_ENQ) begin
                enq_count++;
                if (held_entries.size() >= CAPACITY) begin
                    full_hits++;
                    res.status = ST_FULL;
                end else begin
                    // ahead of the first strictly greater priority
                    pos = 0;
                    while (pos < held_entries.size() && held_entries[pos].prio <= prio)
                        pos++;
                    ent.value = value;
                    ent.prio  = prio;
                    held_entries.insert(pos, ent);
                    res.status = ST_ENQ;
                end
            end else begin
                deq_count++;
                if (held_entries.size() == 0) begin
                    empty_hits++;
                    res.status = ST_EMPTY;
                end else begin
                    ent = held_entries.pop_front();
                    res.status = ST_DEQ;
                    res.value  = ent.value;
                    res.prio   = ent.prio;
                end
            end
            res.occ = OCC_W'(held_entries.size());
            awaited_results.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            checked++;
            if (awaited_results.size() == 0) begin
                flag($sformatf("unexpected result status %0d value %0d prio %0d occ %0d",
                               got.status, got.value, got.prio, got.occ));
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.value !== want.value ||
                got.prio !== want.prio || got.occ !== want.occ)
                flag($sformatf({"result %0d: expected status %0d value %0d prio %0d occ %0d,",
                                " got status %0d value %0d prio %0d occ %0d"},
                               checked, want.status, want.value, want.prio, want.occ,
                               got.status, got.value, got.prio, got.occ));
        endfunction

        function void finish_check();
            while (awaited_results.size() != 0) begin
                void'(awaited_results.pop_front());
                flag("result never arrived");
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_op;
    logic signed [VAL_W-1:0]   i_item_value;
    logic [PRIO_W-1:0]         i_item_priority;
    logic                      o_valid;
    logic                      i_stall;
    logic [STAT_W-1:0]         o_status;
    logic signed [VAL_W-1:0]   o_out_value;
    logic [PRIO_W-1:0]         o_out_priority;
    logic [OCC_W-1:0]          o_occupancy;

    queue_scoreboard sb;
    int              idle_cycles = 0;
    int              send_gap_pct = 0;
    bit              quiet = 1'b0;

    sorted_priority_queue u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_out_value     (o_out_value),
        .o_out_priority  (o_out_priority),
        .o_occupancy     (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : monitor
        bit moved;
        t_result got;
        moved = 1'b0;
        if (i_rst_n) begin
            // result first, so a request taken in the same cycle cannot mask it
            if (o_valid && !i_stall) begin
                got.status = t_status'(o_status);
                got.value  = o_out_value;
                got.prio   = o_out_priority;
                got.occ    = o_occupancy;
                sb.check_result(got);
                moved = 1'b1;
            end
            if (i_valid && !o_stall) begin
                sb.note_request(t_op'(i_op), i_item_value, i_item_priority);
                moved = 1'b1;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : result_backpressure
        int burst;
        int stall_pct;
        burst     = 0;
        stall_pct = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(63) == 0) begin
                case ($urandom_range(3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 30;
                    default: stall_pct = 60;
                endcase
            end
            if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(99) < stall_pct) begin
                burst = $urandom_range(1, 5) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_request(input t_op op, input logic signed [VAL_W-1:0] value,
                                input logic [PRIO_W-1:0] prio);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < send_gap_pct)
            gap = $urandom_range(1, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op            <= op;
        i_item_value    <= value;
        i_item_priority <= prio;
        i_valid         <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int                      n;
        int                      enq_pct;
        t_op                     op;
        logic signed [VAL_W-1:0] value;
        logic [PRIO_W-1:0]       prio;

        sb              = new();
        enq_pct         = 50;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_op            = OP_ENQ;
        i_item_value    = '0;
        i_item_priority = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty dequeue, extremes, ties, fill to full, full enqueue
        send_gap_pct = 20;
        send_request(OP_DEQ, $urandom, PRIO_W'($urandom_range(255)));
        send_request(OP_ENQ, 32'sh7FFFFFFF, 8'd255);
        send_request(OP_ENQ, 32'sh80000000, 8'd0);
        send_request(OP_ENQ, 32'sd0, 8'd128);
        send_request(OP_ENQ, -32'sd1, 8'd128);
        send_request(OP_ENQ, 32'sd1, 8'd128);
        send_request(OP_ENQ, 32'sh55555555, 8'd0);
        send_request(OP_ENQ, 32'shAAAAAAAA, 8'd255);
        for (n = 0; n < CAPACITY - 7; n++)
            send_request(OP_ENQ, $urandom, PRIO_W'($urandom_range(255)));
        send_request(OP_ENQ, -32'sd1, 8'd0);
        repeat (4) send_request(OP_DEQ, $urandom, PRIO_W'($urandom_range(255)));
        wait_for_drain();

        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 25;
                    1: enq_pct = 50;
                    default: enq_pct = 80;
                endcase
                case ($urandom_range(2))
                    0: send_gap_pct = 0;
                    1: send_gap_pct = 15;
                    default: send_gap_pct = 40;
                endcase
            end
            if (n == RANDOM_REQUESTS - QUIET_TAIL)
                quiet = 1'b1;
            if (n % 400 == 399)
                wait_for_drain();
            op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
            case ($urandom_range(15))
                0: value = 32'sh80000000;
                1: value = 32'sh7FFFFFFF;
                2: value = -32'sd1;
                3: value = 32'sd0;
                default: value = $urandom;
            endcase
            case ($urandom_range(7)) inside
                [0:3]: prio = PRIO_W'($urandom_range(255));
                [4:5]: prio = PRIO_W'($urandom_range(3));
                6: prio = $urandom_range(1) ? 8'd255 : 8'd0;
                default: prio = PRIO_W'($urandom_range(255, 252));
            endcase
            send_request(op, value, prio);
        end

        wait_for_drain();
        repeat (4) @(negedge i_clk);
        sb.finish_check();
        $display("Run covered %0d requests: %0d enqueues (%0d refused as full), %0d dequeues",
                 sb.enq_count + sb.deq_count, sb.enq_count, sb.full_hits, sb.deq_count);
        $display("(%0d on empty), %0d results checked, %0d mismatches.",
                 sb.empty_hits, sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sorted_priority_queue.f */
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
sim/tb_top.sv
